>>> hw/rtl/wsm_pkg.sv
package wsm_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_beat_t;

  typedef struct packed {
    logic               result_kind;
    logic signed [31:0] sample;
    logic [1:0]         status_code;
    logic [31:0]        rate_out;
    logic [31:0]        frame_count;
    logic               final_flag;
  } out_beat_t;

  typedef enum logic [6:0] {
    PH_HEADER     = 7'b0000001,
    PH_CHUNK_HEAD = 7'b0000010,
    PH_BODY       = 7'b0000100,
    PH_PAD        = 7'b0001000,
    PH_DATA       = 7'b0010000,
    PH_TAIL       = 7'b0100000,
    PH_FAIL       = 7'b1000000
  } phase_t;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CONV = 5'b00010,
    S_DIV  = 5'b00100,
    S_SAMP = 5'b01000,
    S_STAT = 5'b10000
  } state_t;

  typedef struct packed {
    logic parse;
    logic conv;
    logic div_start;
    logic div_step;
    logic clear;
    logic status_sel;
  } cmd_t;

  typedef struct packed {
    logic samp_complete;
    logic frame_done;
    logic div_last;
  } stat_t;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_WAV     = 2'd1;
  localparam logic [1:0] ST_NO_DATA     = 2'd2;
  localparam logic [1:0] ST_UNSUPPORTED = 2'd3;

  localparam logic [0:0] KIND_SAMPLE = 1'b0;
  localparam logic [0:0] KIND_STATUS = 1'b1;

  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;
  localparam logic [15:0] FMT_PCM        = 16'h0001;
  localparam logic [15:0] FMT_FLOAT      = 16'h0003;
  localparam logic [15:0] FMT_EXTENSIBLE = 16'hFFFE;

  function automatic logic [7:0] magic_byte(input logic [3:0] idx);
    logic [7:0] r;
    unique case (idx)
      4'd0: r = 8'h52;
      4'd1: r = 8'h49;
      4'd2: r = 8'h46;
      4'd3: r = 8'h46;
      4'd8: r = 8'h57;
      4'd9: r = 8'h41;
      4'd10: r = 8'h56;
      4'd11: r = 8'h45;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] float_to_q31(input logic [31:0] w);
    logic [7:0]  e;
    logic [30:0] mant;
    logic [30:0] mag;
    logic [7:0]  sh;
    logic signed [31:0] r;
    e = w[30:23];
    mant = {w[22:0] == 23'd0 ? 1'b1 : 1'b1, w[22:0], 7'd0};
    sh = 8'd126 - e;
    mag = mant >> sh[4:0];
    if (e == 8'hFF) begin
      if (w[22:0] != 23'd0) r = 32'sd0;
      else r = w[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (e == 8'd0 || e < 8'd96) begin
      r = 32'sd0;
    end else if (e >= 8'd127) begin
      r = w[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
    return r;
  endfunction

  function automatic logic signed [31:0] convert_sample(input logic [31:0] w,
                                                       input logic is_float,
                                                       input logic [2:0] sbytes);
    logic signed [31:0] r;
    if (is_float) begin
      r = float_to_q31(w);
    end else begin
      unique case (sbytes)
        3'd1: r = $signed({~w[7], w[6:0], 24'd0});
        3'd2: r = $signed({w[15:0], 16'd0});
        3'd3: r = $signed({w[23:0], 8'd0});
        default: r = $signed(w);
      endcase
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/wsm_ctrl.sv
module wsm_ctrl
  import wsm_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  logic  in_last,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state, state_next;
  logic   last_pend, last_pend_next;
  logic   in_acc;
  logic   out_acc;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_SAMP) || (state == S_STAT);
  assign in_acc    = in_valid && (state == S_IDLE);
  assign out_acc   = out_valid && !out_stall;

  always_comb begin
    state_next = state;
    last_pend_next = last_pend;
    cmd = '0;
    cmd.status_sel = (state == S_STAT);
    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          cmd.parse = 1'b1;
          last_pend_next = in_last;
          if (stat.samp_complete) state_next = S_CONV;
          else if (in_last) state_next = S_STAT;
        end
      end
      S_CONV: begin
        cmd.conv = 1'b1;
        if (stat.frame_done) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else if (last_pend) begin
          state_next = S_STAT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_next = S_SAMP;
      end
      S_SAMP: begin
        if (out_acc) state_next = last_pend ? S_STAT : S_IDLE;
      end
      S_STAT: begin
        if (out_acc) begin
          cmd.clear = 1'b1;
          last_pend_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      last_pend <= 1'b0;
    end else begin
      state <= state_next;
      last_pend <= last_pend_next;
    end
  end

endmodule

>>> hw/rtl/wsm_dp.sv
module wsm_dp
  import wsm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_data,
  input  cmd_t      cmd,
  output stat_t     stat,
  output out_beat_t out_data
);

  localparam int ACC_W = 32 + $clog2(MAX_CHANNELS);
  localparam int CH_W  = $clog2(MAX_CHANNELS + 1);
  localparam int CNT_W = $clog2(ACC_W);

  phase_t       phase;
  logic [31:0]  pos, tag, len, rate, frames;
  logic [15:0]  fmt_code, chans, bits;
  logic [2:0]   sbytes;
  logic [7:0]   ext_lo;
  logic [CH_W-1:0] ch_idx;
  logic signed [ACC_W-1:0] acc;
  logic         fmt_seen, capture;
  logic [1:0]   fail_code;
  logic [ACC_W-1:0] q;
  logic [CH_W-1:0]  rem;
  logic         neg;
  logic [CNT_W-1:0] dcnt;

  logic [7:0]   b;
  logic [31:0]  pos_inc, len_full;
  logic         hdr_bad, bad2, bad3, fmt_ok;
  logic signed [31:0] cv;
  logic signed [ACC_W-1:0] acc_sum;
  logic [ACC_W-1:0] mag;
  logic [CH_W-1:0]  dvs;
  logic [CH_W:0]    rem_sh;
  logic         ge;
  logic [1:0]   code;
  logic signed [31:0] quo;

  assign b        = in_data.byte_value;
  assign pos_inc  = pos + 32'd1;
  assign len_full = {b, len[23:0]};
  assign hdr_bad  = (pos < 32'd4 || pos >= 32'd8) && (b != magic_byte(pos[3:0]));
  assign bad2     = (chans == 16'd0) || (rate == 32'd0) || rate[31];
  assign fmt_ok   = ((fmt_code == FMT_PCM) && (bits == 16'd8 || bits == 16'd16 ||
                     bits == 16'd24 || bits == 16'd32)) ||
                    ((fmt_code == FMT_FLOAT) && (bits == 16'd32));
  assign bad3     = !fmt_ok || (chans > 16'(MAX_CHANNELS));

  assign cv      = convert_sample(tag, fmt_code == FMT_FLOAT, sbytes);
  assign acc_sum = acc + ACC_W'(cv);
  assign mag     = acc_sum[ACC_W-1] ? ACC_W'(-acc_sum) : ACC_W'(acc_sum);
  assign dvs     = chans[CH_W-1:0];
  assign rem_sh  = {rem, q[ACC_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs};
  assign quo     = neg ? -$signed(q[31:0]) : $signed(q[31:0]);

  assign stat.samp_complete = (phase == PH_DATA) && (pos_inc >= {29'd0, sbytes});
  assign stat.frame_done = ((CH_W+1)'(ch_idx) + (CH_W+1)'(1)) >= {1'b0, dvs};
  assign stat.div_last = (dcnt == CNT_W'(ACC_W - 1));

  always_comb begin
    unique case (phase)
      PH_HEADER: code = ST_NOT_WAV;
      PH_FAIL: code = fail_code;
      PH_DATA, PH_TAIL: code = ST_OK;
      default: code = ST_NO_DATA;
    endcase
  end

  always_comb begin
    if (cmd.status_sel) begin
      out_data.result_kind = KIND_STATUS;
      out_data.sample      = 32'sd0;
      out_data.status_code = code;
      out_data.rate_out    = (code == ST_OK) ? rate : 32'd0;
      out_data.frame_count = (code == ST_OK) ? frames : 32'd0;
      out_data.final_flag  = 1'b1;
    end else begin
      out_data.result_kind = KIND_SAMPLE;
      out_data.sample      = quo;
      out_data.status_code = ST_OK;
      out_data.rate_out    = rate;
      out_data.frame_count = frames;
      out_data.final_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      phase <= PH_HEADER;
      pos <= '0; tag <= '0; len <= '0; rate <= '0; frames <= '0;
      fmt_code <= '0; chans <= '0; bits <= '0; sbytes <= '0; ext_lo <= '0;
      ch_idx <= '0; acc <= '0; fmt_seen <= 1'b0; capture <= 1'b0;
      fail_code <= ST_OK;
    end else if (cmd.parse) begin
      unique case (phase)
        PH_HEADER: begin
          if (hdr_bad) begin
            phase <= PH_FAIL;
            fail_code <= ST_NOT_WAV;
          end else if (pos_inc >= 32'd12) begin
            pos <= '0;
            phase <= PH_CHUNK_HEAD;
          end else begin
            pos <= pos_inc;
          end
        end
        PH_CHUNK_HEAD: begin
          unique case (pos[2:0])
            3'd0: tag <= {24'd0, b};
            3'd1: tag[15:8] <= b;
            3'd2: tag[23:16] <= b;
            3'd3: tag[31:24] <= b;
            3'd4: len <= {24'd0, b};
            3'd5: len[15:8] <= b;
            3'd6: len[23:16] <= b;
            default: len[31:24] <= b;
          endcase
          pos <= pos_inc;
          if (pos[2:0] == 3'd7) begin
            pos <= '0;
            if (tag == TAG_DATA && fmt_seen) begin
              if (bad2) begin
                phase <= PH_FAIL;
                fail_code <= ST_NO_DATA;
              end else if (bad3) begin
                phase <= PH_FAIL;
                fail_code <= ST_UNSUPPORTED;
              end else begin
                sbytes <= bits[5:3];
                ch_idx <= '0;
                acc <= '0;
                tag <= '0;
                phase <= (len_full == 32'd0) ? PH_TAIL : PH_DATA;
              end
            end else begin
              if (tag == TAG_FMT && len_full >= 32'd16) capture <= 1'b1;
              phase <= (len_full == 32'd0) ? PH_CHUNK_HEAD : PH_BODY;
            end
          end
        end
        PH_BODY: begin
          if (capture) begin
            priority case (pos)
              32'd0: fmt_code <= {8'd0, b};
              32'd1: fmt_code[15:8] <= b;
              32'd2: chans <= {8'd0, b};
              32'd3: chans[15:8] <= b;
              32'd4: rate <= {24'd0, b};
              32'd5: rate[15:8] <= b;
              32'd6: rate[23:16] <= b;
              32'd7: rate[31:24] <= b;
              32'd14: bits <= {8'd0, b};
              32'd15: begin
                bits[15:8] <= b;
                fmt_seen <= 1'b1;
              end
              32'd24: ext_lo <= b;
              32'd25: if (fmt_code == FMT_EXTENSIBLE) fmt_code <= {b, ext_lo};
              default: ;
            endcase
          end
          pos <= pos_inc;
          if (pos_inc == len) begin
            pos <= '0;
            capture <= 1'b0;
            phase <= len[0] ? PH_PAD : PH_CHUNK_HEAD;
          end
        end
        PH_PAD: phase <= PH_CHUNK_HEAD;
        PH_DATA: begin
          unique case (pos[1:0])
            2'd0: tag <= {24'd0, b};
            2'd1: tag[15:8] <= b;
            2'd2: tag[23:16] <= b;
            default: tag[31:24] <= b;
          endcase
          pos <= stat.samp_complete ? 32'd0 : pos_inc;
          len <= len - 32'd1;
          if (len == 32'd1) phase <= PH_TAIL;
        end
        default: ;
      endcase
    end else if (cmd.conv) begin
      if (stat.frame_done) begin
        acc <= '0;
        ch_idx <= '0;
        frames <= frames + 32'd1;
      end else begin
        acc <= acc_sum;
        ch_idx <= ch_idx + CH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q <= mag;
      rem <= '0;
      neg <= acc_sum[ACC_W-1];
      dcnt <= '0;
    end else if (cmd.div_step) begin
      rem <= ge ? CH_W'(rem_sh - {1'b0, dvs}) : rem_sh[CH_W-1:0];
      q <= {q[ACC_W-2:0], ge};
      dcnt <= dcnt + CNT_W'(1);
    end
  end

endmodule

>>> hw/rtl/wav_stream_to_mono_pcm_top.sv
// Streaming WAV decoder: takes one file byte per beat, checks the RIFF/WAVE
// header, walks chunks, reads the fmt chunk and decodes the first data chunk
// after it into one channel-averaged Q1.31 sample per frame, then gives a final
// status beat on the last byte and starts over for the next file. Bytes are
// accepted only in the idle state; the byte that completes a sample is followed
// by a conversion step, and the byte that completes a frame also by a bit-serial
// division of the channel sum by the channel count and then by the offered sample
// beat, held while the output stalls. The last byte of a file likewise leads to
// the status beat. The input is stalled for as long as any of these steps runs.
module wav_stream_to_mono_pcm_top
  import wsm_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  in_beat_t  in_data,
  input  logic      in_valid,
  output logic      in_stall,
  output out_beat_t out_data,
  output logic      out_valid,
  input  logic      out_stall
);

  cmd_t  cmd;
  stat_t stat;

  wsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_last   (in_data.last_byte),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  wsm_dp #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
